/* rtl/core/alu32_with_flags_assert.svh */
// assertion macros shared by the alu rtl
// expects clk and rst_n in the including scope
`ifndef ALU32_WITH_FLAGS_ASSERT_SVH
`define ALU32_WITH_FLAGS_ASSERT_SVH

// antecedent implies consequent, off during reset
`define ALU_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must never hold outside reset
`define ALU_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* rtl/core/alu_pkg.sv */
// shared types and constants of the 32-bit alu
// no dependencies
`default_nettype none

package alu_pkg;

    localparam int WORD_W    = 32;
    localparam int DIV_STEPS = WORD_W;

    localparam logic [WORD_W-1:0] MSB_WORD = 32'h8000_0000;
    localparam logic [WORD_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] ONE_WORD = 32'h0000_0001;

    typedef enum logic [4:0] {
        OP_MOV_RR  = 5'd0,
        OP_MOV_IMM = 5'd1,
        OP_AND     = 5'd2,
        OP_OR      = 5'd3,
        OP_XOR     = 5'd4,
        OP_NOT     = 5'd5,
        OP_NAND    = 5'd6,
        OP_NOR     = 5'd7,
        OP_XNOR    = 5'd8,
        OP_SHL     = 5'd9,
        OP_SHR     = 5'd10,
        OP_ADD     = 5'd11,
        OP_SADD    = 5'd12,
        OP_SUB     = 5'd13,
        OP_SSUB    = 5'd14,
        OP_MUL     = 5'd15,
        OP_SMUL    = 5'd16,
        OP_DIV     = 5'd17,
        OP_SDIV    = 5'd18,
        OP_MOD     = 5'd19,
        OP_SMOD    = 5'd20,
        OP_INC     = 5'd21,
        OP_DEC     = 5'd22,
        OP_CMP     = 5'd23
    } op_t;

    // everything an item carries alongside the divider
    typedef struct packed {
        op_t               op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] res;
        logic              cf;
        logic              of;
        logic              wb;
        logic              keep_a;
        logic              force_zs;
        logic              sel_quo;
        logic              sel_rem;
        logic              neg_q;
        logic              neg_r;
    } side_t;

endpackage

`default_nettype wire

/* rtl/core/alu_div.sv */
// pipelined restoring divider, one quotient bit per stage
// depends on alu_pkg; carries side_t along with each beat
`default_nettype none

module alu_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire alu_pkg::side_t                in_side,
    input  wire logic [alu_pkg::WORD_W-1:0]    in_dvd,
    input  wire logic [alu_pkg::WORD_W-1:0]    in_dvs,
    output logic                               out_valid,
    output alu_pkg::side_t                     out_side,
    output logic [alu_pkg::WORD_W-1:0]         out_quo,
    output logic [alu_pkg::WORD_W-1:0]         out_rem
);

    localparam int N = alu_pkg::DIV_STEPS;
    localparam int W = alu_pkg::WORD_W;

    logic [N-1:0]   vld_reg;
    alu_pkg::side_t side_reg [N];
    logic [W-1:0]   rem_reg  [N];
    logic [W-1:0]   quo_reg  [N];
    logic [W-1:0]   dvs_reg  [N];
    logic [W-1:0]   rem_next [N];
    logic [W-1:0]   quo_next [N];

    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            logic [W-1:0] rem_i;
            logic [W-1:0] quo_i;
            logic [W-1:0] dvs_i;
            logic [W:0]   shifted;
            logic [W:0]   diff;
            rem_i = (k == 0) ? '0     : rem_reg[(k == 0) ? 0 : k-1];
            quo_i = (k == 0) ? in_dvd : quo_reg[(k == 0) ? 0 : k-1];
            dvs_i = (k == 0) ? in_dvs : dvs_reg[(k == 0) ? 0 : k-1];
            shifted = {rem_i, quo_i[W-1]};
            diff    = shifted - {1'b0, dvs_i};
            // a set top bit means the trial subtract went negative
            rem_next[k] = diff[W] ? shifted[W-1:0] : diff[W-1:0];
            quo_next[k] = {quo_i[W-2:0], ~diff[W]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            quo_reg[k]  <= quo_next[k];
            dvs_reg[k]  <= (k == 0) ? in_dvs  : dvs_reg[(k == 0) ? 0 : k-1];
            side_reg[k] <= (k == 0) ? in_side : side_reg[(k == 0) ? 0 : k-1];
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_side  = side_reg[N-1];
    assign out_quo   = quo_reg[N-1];
    assign out_rem   = rem_reg[N-1];

endmodule

`default_nettype wire

/* rtl/core/alu32_with_flags.sv */
// 32-bit alu with carry, zero, sign and overflow flags, fully pipelined
// depends on alu_pkg, alu_div and alu32_with_flags_assert.svh
//
// usage: drive operation, operand_a and operand_b with start high for one
// cycle per item; the beat is taken when start is high and busy is low.
// busy is always low: a new item may enter in every clock cycle.
// every item takes the same path: decode and simple ops, multiply fixup,
// then 32 divider stages and an output register, so results come out
// in order, one result per item.
// the divider takes one quotient bit per stage; throughput is
// one item per cycle.
// done is high for one cycle with result_value, write_back and the four
// flags; the receiver cannot stall, so results are never held back.
// reset clears all valid bits, so no result comes out of items in flight.
`default_nettype none

module alu32_with_flags (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [4:0]  operation,
    input  wire logic [31:0] operand_a,
    input  wire logic [31:0] operand_b,
    output logic             done,
    output logic [31:0]      result_value,
    output logic             write_back,
    output logic             carry_flag,
    output logic             zero_flag,
    output logic             sign_flag,
    output logic             overflow_flag
);

    localparam int W = alu_pkg::WORD_W;

    // stage 1: simple ops, raw product, divider setup
    logic           v1_reg;
    alu_pkg::side_t s1_reg, s1_next;
    logic [W-1:0]   b1_reg;
    logic [2*W-1:0] prod1_reg;
    logic [W-1:0]   dvd1_reg, dvd1_next;
    logic [W-1:0]   dvs1_reg, dvs1_next;

    // stage 2: product result and flag fixup, unsigned and signed
    logic           v2_reg;
    alu_pkg::side_t s2_reg, s2_next;
    logic [W-1:0]   dvd2_reg;
    logic [W-1:0]   dvs2_reg;

    // divider outputs
    logic           dv_valid;
    alu_pkg::side_t dv_side;
    logic [W-1:0]   dv_quo;
    logic [W-1:0]   dv_rem;

    logic [W-1:0]   res_reg, res_next;
    logic           done_reg;
    logic           wb_reg, cf_reg, zf_reg, sf_reg, of_reg;
    logic           wb_next, cf_next, zf_next, sf_next, of_next;

    alu_pkg::op_t   op_in;
    logic [W:0]     sum_w;
    logic [W:0]     diff_w;
    logic           sa, sb;

    assign busy  = 1'b0;
    assign op_in = alu_pkg::op_t'(operation);
    assign sa    = operand_a[W-1];
    assign sb    = operand_b[W-1];
    assign sum_w  = {1'b0, operand_a} + {1'b0, operand_b};
    assign diff_w = {1'b0, operand_a} - {1'b0, operand_b};

    always_comb
    begin
        s1_next          = '0;
        s1_next.op       = op_in;
        s1_next.a        = operand_a;
        s1_next.res      = operand_a;
        s1_next.wb       = 1'b1;
        dvd1_next        = operand_a;
        dvs1_next        = operand_b;
        unique case (op_in)
            alu_pkg::OP_MOV_RR, alu_pkg::OP_MOV_IMM: s1_next.res = operand_b;
            alu_pkg::OP_AND:  s1_next.res = operand_a & operand_b;
            alu_pkg::OP_OR:   s1_next.res = operand_a | operand_b;
            alu_pkg::OP_XOR:  s1_next.res = operand_a ^ operand_b;
            alu_pkg::OP_NOT:  s1_next.res = ~operand_a;
            alu_pkg::OP_NAND: s1_next.res = ~(operand_a & operand_b);
            alu_pkg::OP_NOR:  s1_next.res = ~(operand_a | operand_b);
            alu_pkg::OP_XNOR: s1_next.res = ~(operand_a ^ operand_b);
            alu_pkg::OP_SHL:
            begin
                s1_next.res = {operand_a[W-2:0], 1'b0};
                s1_next.cf  = sa;
                s1_next.of  = operand_a[W-2] ^ sa;
            end
            alu_pkg::OP_SHR:
            begin
                s1_next.res = {1'b0, operand_a[W-1:1]};
                s1_next.cf  = operand_a[0];
            end
            alu_pkg::OP_ADD, alu_pkg::OP_SADD:
            begin
                s1_next.res = sum_w[W-1:0];
                s1_next.cf  = sum_w[W];
                s1_next.of  = (sa == sb) && (sum_w[W-1] != sa);
            end
            alu_pkg::OP_SUB, alu_pkg::OP_SSUB, alu_pkg::OP_CMP:
            begin
                s1_next.res    = diff_w[W-1:0];
                s1_next.cf     = diff_w[W];
                s1_next.of     = (sa != sb) && (diff_w[W-1] != sa);
                s1_next.wb     = (op_in != alu_pkg::OP_CMP);
                s1_next.keep_a = (op_in == alu_pkg::OP_CMP);
            end
            alu_pkg::OP_MUL, alu_pkg::OP_SMUL: s1_next.res = operand_a;
            alu_pkg::OP_DIV, alu_pkg::OP_SDIV, alu_pkg::OP_MOD, alu_pkg::OP_SMOD:
            begin
                if (operand_b == '0)
                begin
                    // divide by zero: keep a, flag error
                    s1_next.wb       = 1'b0;
                    s1_next.cf       = 1'b1;
                    s1_next.of       = 1'b1;
                    s1_next.keep_a   = 1'b1;
                    s1_next.force_zs = 1'b1;
                end
                else
                begin
                    s1_next.sel_quo = (op_in == alu_pkg::OP_DIV) || (op_in == alu_pkg::OP_SDIV);
                    s1_next.sel_rem = (op_in == alu_pkg::OP_MOD) || (op_in == alu_pkg::OP_SMOD);
                    if ((op_in == alu_pkg::OP_SDIV) || (op_in == alu_pkg::OP_SMOD))
                    begin
                        dvd1_next      = sa ? (~operand_a + alu_pkg::ONE_WORD) : operand_a;
                        dvs1_next      = sb ? (~operand_b + alu_pkg::ONE_WORD) : operand_b;
                        s1_next.neg_q  = sa ^ sb;
                        s1_next.neg_r  = sa;
                        s1_next.of     = (op_in == alu_pkg::OP_SDIV)
                                         && (operand_a == alu_pkg::MSB_WORD)
                                         && (operand_b == alu_pkg::ALL_ONES);
                    end
                end
            end
            alu_pkg::OP_INC:
            begin
                s1_next.res = operand_a + alu_pkg::ONE_WORD;
                s1_next.cf  = (operand_a == alu_pkg::ALL_ONES);
                s1_next.of  = (operand_a == ~alu_pkg::MSB_WORD);
            end
            alu_pkg::OP_DEC:
            begin
                s1_next.res = operand_a - alu_pkg::ONE_WORD;
                s1_next.cf  = (operand_a == '0);
                s1_next.of  = (operand_a == alu_pkg::MSB_WORD);
            end
            default:
            begin
                // unused code: pass a through, no write, flags clear
                s1_next.wb       = 1'b0;
                s1_next.keep_a   = 1'b1;
                s1_next.force_zs = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            done_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg    <= s1_next;
        b1_reg    <= operand_b;
        prod1_reg <= {{W{1'b0}}, operand_a} * {{W{1'b0}}, operand_b};
        dvd1_reg  <= dvd1_next;
        dvs1_reg  <= dvs1_next;
        s2_reg    <= s2_next;
        dvd2_reg  <= dvd1_reg;
        dvs2_reg  <= dvs1_reg;
    end

    // signed high half from the unsigned product
    logic [W-1:0] hi_u, hi_s, lo_p;
    assign lo_p = prod1_reg[W-1:0];
    assign hi_u = prod1_reg[2*W-1:W];
    assign hi_s = hi_u - (s1_reg.a[W-1] ? b1_reg : '0) - (b1_reg[W-1] ? s1_reg.a : '0);

    always_comb
    begin
        s2_next = s1_reg;
        if (s1_reg.op == alu_pkg::OP_MUL)
        begin
            s2_next.res = lo_p;
            s2_next.cf  = (hi_u != '0);
            s2_next.of  = (hi_u != '0);
        end
        else if (s1_reg.op == alu_pkg::OP_SMUL)
        begin
            s2_next.res = lo_p;
            s2_next.cf  = (hi_s != {W{lo_p[W-1]}});
            s2_next.of  = (hi_s != {W{lo_p[W-1]}});
        end
    end

    alu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .in_side   (s2_reg),
        .in_dvd    (dvd2_reg),
        .in_dvs    (dvs2_reg),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .out_quo   (dv_quo),
        .out_rem   (dv_rem)
    );

    logic [W-1:0] val;

    always_comb
    begin
        priority if (dv_side.sel_quo)
            val = dv_side.neg_q ? (~dv_quo + alu_pkg::ONE_WORD) : dv_quo;
        else if (dv_side.sel_rem)
            val = dv_side.neg_r ? (~dv_rem + alu_pkg::ONE_WORD) : dv_rem;
        else
            val = dv_side.res;
        res_next = dv_side.keep_a ? dv_side.a : val;
        wb_next  = dv_side.wb;
        cf_next  = dv_side.cf;
        of_next  = dv_side.of;
        zf_next  = !dv_side.force_zs && (val == '0);
        sf_next  = !dv_side.force_zs && val[W-1];
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        wb_reg  <= wb_next;
        cf_reg  <= cf_next;
        zf_reg  <= zf_next;
        sf_reg  <= sf_next;
        of_reg  <= of_next;
    end

    assign done          = done_reg;
    assign result_value  = res_reg;
    assign write_back    = wb_reg;
    assign carry_flag    = cf_reg;
    assign zero_flag     = zf_reg;
    assign sign_flag     = sf_reg;
    assign overflow_flag = of_reg;

`include "alu32_with_flags_assert.svh"

    `ALU_ASSERT_NEVER(a_never_busy, busy, "busy raised")
    `ALU_ASSERT_IMPL(a_fixed_latency, start, ##35 done, "result missing after 35 cycles")
    `ALU_ASSERT_IMPL(a_zero_not_neg, done && zero_flag, !sign_flag, "zero and sign both set")

endmodule

`default_nettype wire
